// ----- sv/i2c_reg_pkg.sv -----
// shared types and constants for the i2c register master
package i2c_reg_pkg;

  localparam logic [15:0] QuarterReset = 16'd5;
  localparam logic [7:0]  StretchReset = 8'd99;
  localparam int unsigned QueueDepth   = 2;

  localparam logic [1:0] OpTick  = 2'd0;
  localparam logic [1:0] OpWrite = 2'd1;
  localparam logic [1:0] OpRead  = 2'd2;
  localparam logic [1:0] OpByte  = 2'd3;

  localparam logic CfgQuarter = 1'b0;
  localparam logic CfgStretch = 1'b1;

  typedef enum logic [4:0] {
    PIdle, PStart, PWbLo1, PWbLo2, PWbHi1, PWbHi2, PAckLo1, PAckLo2, PAckStr,
    PAckHi1, PAckHi2, PRsLo1, PRsLo2, PRsHi, PWait, PRbLo1, PRbLo2, PRbHi1,
    PRbHi2, PRaLo1, PRaLo2, PRaHi1, PRaHi2, PSpLo1, PSpLo2, PSpHi, PSpEnd1,
    PSpEnd2
  } phase_e;

  typedef enum logic [1:0] {KDev, KSub, KDevr, KData} kind_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] device_addr;
    logic [7:0] sub_addr;
    logic [7:0] byte_count;
    logic [7:0] write_byte;
    logic       sda_in;
    logic       scl_in;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       scl_drive;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       byte_request;
    logic [7:0] read_data;
    logic       read_valid;
    logic       done_res;
    logic       success;
  } result_t;

endpackage

// ----- sv/i2c_reg_engine.sv -----
// bus sequencer: one tick per beat, produces one result per tick
module i2c_reg_engine import i2c_reg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [15:0] quarter_i,
  input  logic [7:0] stretch_i,
  input  logic       step_i,
  input  item_t      item_i,
  output result_t    res_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] tick_q, tick_d;
  logic [3:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d, left_q, left_d, str_q, str_d, dev_q, dev_d, sub_q, sub_d;
  logic        rmode_q, rmode_d, ok_q, ok_d;
  kind_e       kind_q, kind_d;
  logic [15:0] qp;
  logic        tdone, wbit, ackl;

  assign qp    = (quarter_i == 16'd0) ? 16'd1 : quarter_i;
  assign tdone = ({1'b0, tick_q} + 17'd1) >= {1'b0, qp};
  assign wbit  = shift_q[3'd7 - bit_q[2:0]];
  assign ackl  = (left_q == 8'd0);

  always_comb begin
    res_o = '0;
    res_o.scl_level = 1'b1;
    res_o.scl_drive = 1'b1;
    res_o.sda_level = 1'b1;
    res_o.sda_drive = 1'b1;
    unique case (phase_q)
      PStart: res_o.sda_level = 1'b0;
      PWbLo1, PWbLo2: begin res_o.scl_level = 1'b0; res_o.sda_level = wbit; end
      PWbHi1, PWbHi2: res_o.sda_level = wbit;
      PAckLo1, PAckLo2, PRbLo1, PRbLo2: begin
        res_o.scl_level = 1'b0; res_o.sda_drive = 1'b0;
      end
      PAckStr: begin res_o.scl_drive = 1'b0; res_o.sda_drive = 1'b0; end
      PAckHi1, PRbHi1, PRbHi2: res_o.sda_drive = 1'b0;
      PRsLo1, PRsLo2, PWait: res_o.scl_level = 1'b0;
      PRaLo1, PRaLo2: begin res_o.scl_level = 1'b0; res_o.sda_level = ackl; end
      PRaHi1, PRaHi2: res_o.sda_level = ackl;
      PSpLo1, PSpLo2: begin res_o.scl_level = 1'b0; res_o.sda_level = 1'b0; end
      PSpHi: res_o.sda_level = 1'b0;
      default: ;
    endcase
    res_o.busy_res     = (phase_q != PIdle);
    res_o.byte_request = (phase_q == PWait);
    if (phase_q == PRbHi1 && tdone && bit_q == 4'd7) begin
      res_o.read_valid = 1'b1;
      res_o.read_data  = {shift_q[6:0], item_i.sda_in};
    end
    if (phase_q == PSpEnd2 && tdone) begin
      res_o.done_res = 1'b1;
      res_o.success  = ok_q;
    end
  end

  always_comb begin
    phase_d = phase_q; tick_d = tick_q; bit_d = bit_q; shift_d = shift_q;
    left_d = left_q; str_d = str_q; dev_d = dev_q; sub_d = sub_q;
    rmode_d = rmode_q; ok_d = ok_q; kind_d = kind_q;
    if (!(phase_q == PIdle || phase_q == PWait || phase_q == PAckStr))
      tick_d = tdone ? 16'd0 : tick_q + 16'd1;
    unique case (phase_q)
      PIdle: if (item_i.opcode == OpWrite || item_i.opcode == OpRead) begin
        dev_d = item_i.device_addr; sub_d = item_i.sub_addr;
        left_d = item_i.byte_count; rmode_d = (item_i.opcode == OpRead);
        kind_d = KDev; ok_d = 1'b1; shift_d = item_i.device_addr;
        bit_d = 4'd0; phase_d = PStart; tick_d = 16'd0;
      end
      PStart: if (tdone) begin bit_d = 4'd0; phase_d = PWbLo1; end
      PWbHi2, PRbHi2: if (tdone) begin
        bit_d = bit_q + 4'd1;
        if (phase_q == PWbHi2) phase_d = (bit_q + 4'd1 >= 4'd8) ? PAckLo1 : PWbLo1;
        else phase_d = (bit_q + 4'd1 >= 4'd8) ? PRaLo1 : PRbLo1;
      end
      PAckLo2: if (tdone) begin str_d = 8'd0; phase_d = PAckStr; end
      PAckStr: begin
        if (tick_q != 16'd0) tick_d = tick_q - 16'd1;
        else if (item_i.scl_in || ({1'b0, str_q} + 9'd1) >= {1'b0, stretch_i}) begin
          phase_d = PAckHi1; tick_d = 16'd0;
        end else begin
          str_d = str_q + 8'd1; tick_d = qp - 16'd1;
        end
      end
      PAckHi1: if (tdone) begin
        if (item_i.sda_in && kind_q != KData) ok_d = 1'b0;
        phase_d = PAckHi2;
      end
      PAckHi2: if (tdone) begin
        if (!ok_q) phase_d = PSpLo1;
        else begin
          unique case (kind_q)
            KDev: begin kind_d = KSub; shift_d = sub_q; bit_d = 4'd0; phase_d = PWbLo1; end
            KSub: if (rmode_q) phase_d = PRsLo1;
                  else begin kind_d = KData; phase_d = ackl ? PSpLo1 : PWait; end
            KDevr: begin
              kind_d = KData;
              if (!ackl) begin
                left_d = left_q - 8'd1; shift_d = 8'd0; bit_d = 4'd0; phase_d = PRbLo1;
              end else phase_d = PSpLo1;
            end
            default: phase_d = ackl ? PSpLo1 : PWait;
          endcase
        end
      end
      PRsHi: if (tdone) begin
        kind_d = KDevr; shift_d = dev_q | 8'd1; phase_d = PStart;
      end
      PWait: if (item_i.opcode == OpByte) begin
        left_d = left_q - 8'd1; shift_d = item_i.write_byte; bit_d = 4'd0;
        phase_d = PWbLo1; tick_d = 16'd0;
      end
      PRbHi1: if (tdone) begin
        shift_d = {shift_q[6:0], item_i.sda_in}; phase_d = PRbHi2;
      end
      PRaHi2: if (tdone) begin
        if (!ackl) begin
          left_d = left_q - 8'd1; shift_d = 8'd0; bit_d = 4'd0; phase_d = PRbLo1;
        end else phase_d = PSpLo1;
      end
      PSpEnd2: if (tdone) phase_d = PIdle;
      PWbLo1, PWbLo2, PWbHi1, PAckLo1, PRsLo1, PRsLo2, PRbLo1, PRbLo2, PRaLo1,
      PRaLo2, PRaHi1, PSpLo1, PSpLo2, PSpHi, PSpEnd1:
        if (tdone) phase_d = phase_e'(phase_q + 5'd1);
      default: begin phase_d = PIdle; tick_d = 16'd0; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PIdle; tick_q <= '0; bit_q <= '0; shift_q <= '0; left_q <= '0;
      str_q <= '0; dev_q <= '0; sub_q <= '0; rmode_q <= 1'b0; ok_q <= 1'b0;
      kind_q <= KDev;
    end else if (step_i) begin
      phase_q <= phase_d; tick_q <= tick_d; bit_q <= bit_d; shift_q <= shift_d;
      left_q <= left_d; str_q <= str_d; dev_q <= dev_d; sub_q <= sub_d;
      rmode_q <= rmode_d; ok_q <= ok_d; kind_q <= kind_d;
    end
  end

endmodule

// ----- sv/i2c_reg_queue.sv -----
// small result queue between the sequencer and the result port
module i2c_reg_queue import i2c_reg_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_i,
  input  result_t data_i,
  output logic    full_o,
  input  logic    rd_i,
  output logic    empty_o,
  output result_t data_o
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  result_t          mem_q [Depth];
  logic [Aw-1:0]    wp_q, rp_q;
  logic [Aw:0]      cnt_q;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == Aw'(0) + (Aw+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (do_wr) wp_q <= (wp_q == Aw'(Depth - 1)) ? '0 : wp_q + Aw'(1);
      if (do_rd) rp_q <= (rp_q == Aw'(Depth - 1)) ? '0 : rp_q + Aw'(1);
      cnt_q <= cnt_q + (Aw+1)'(do_wr) - (Aw+1)'(do_rd);
    end
  end

endmodule

// ----- sv/i2c_register_master.sv -----
// top level of the i2c register master
// Each input beat is one bus clock tick; a beat is taken every cycle while the
// two-entry result queue has room, and its result is written into that queue. The
// sequencer register file advances once per accepted beat, so the rate is one
// beat per cycle, limited only by results being popped.
module i2c_register_master import i2c_reg_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  device_addr_i,
  input  logic [7:0]  sub_addr_i,
  input  logic [7:0]  byte_count_i,
  input  logic [7:0]  write_byte_i,
  input  logic        sda_in_i,
  input  logic        scl_in_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        empty,
  input  logic        pop,
  output logic        scl_level_o,
  output logic        scl_drive_o,
  output logic        sda_level_o,
  output logic        sda_drive_o,
  output logic        busy_res_o,
  output logic        byte_request_o,
  output logic [7:0]  read_data_o,
  output logic        read_valid_o,
  output logic        done_res_o,
  output logic        success_o
);

  logic [15:0] quarter_q;
  logic [7:0]  stretch_q;
  logic        step;
  item_t       item;
  result_t     res, outq;

  assign cfg_ready_o = 1'b1;
  assign step = push && !full;
  assign item = '{opcode: opcode_i, device_addr: device_addr_i, sub_addr: sub_addr_i,
                  byte_count: byte_count_i, write_byte: write_byte_i,
                  sda_in: sda_in_i, scl_in: scl_in_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quarter_q <= QuarterReset;
      stretch_q <= StretchReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgQuarter: quarter_q <= cfg_data_i;
        CfgStretch: stretch_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  i2c_reg_engine u_engine (
    .clk_i, .rst_ni, .quarter_i(quarter_q), .stretch_i(stretch_q),
    .step_i(step), .item_i(item), .res_o(res)
  );

  i2c_reg_queue #(.Depth(Depth)) u_queue (
    .clk_i, .rst_ni, .wr_i(step), .data_i(res), .full_o(full),
    .rd_i(pop), .empty_o(empty), .data_o(outq)
  );

  assign scl_level_o    = outq.scl_level;
  assign scl_drive_o    = outq.scl_drive;
  assign sda_level_o    = outq.sda_level;
  assign sda_drive_o    = outq.sda_drive;
  assign busy_res_o     = outq.busy_res;
  assign byte_request_o = outq.byte_request;
  assign read_data_o    = outq.read_data;
  assign read_valid_o   = outq.read_valid;
  assign done_res_o     = outq.done_res;
  assign success_o      = outq.success;

endmodule

// ----- sv/i2c_reg_checker.sv -----
// port-level checks for the i2c register master, bound to the top level
module i2c_reg_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop,
  input logic read_valid_o,
  input logic done_res_o,
  input logic success_o,
  input logic busy_res_o,
  input logic scl_drive_o,
  input logic sda_drive_o
);

  a_succ_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && success_o |-> done_res_o) else $error("success without done");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && done_res_o |-> busy_res_o) else $error("done while idle");

  a_idle_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !busy_res_o |-> scl_drive_o && sda_drive_o) else $error("idle lines released");

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full |=> !empty) else $error("beat lost");

  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && read_valid_o |-> !done_res_o) else $error("read and done together");

endmodule

bind i2c_register_master i2c_reg_checker u_checker (.*);

// ----- tb/tb.sv -----
// testbench for the i2c register master: tick stream checked against a cycle model
module tb;
  import i2c_reg_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  opcode_i = OpTick;
  logic [7:0]  device_addr_i = '0;
  logic [7:0]  sub_addr_i = '0;
  logic [7:0]  byte_count_i = '0;
  logic [7:0]  write_byte_i = '0;
  logic        sda_in_i = 1'b0;
  logic        scl_in_i = 1'b1;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = CfgQuarter;
  logic [15:0] cfg_data_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        scl_level_o, scl_drive_o, sda_level_o, sda_drive_o;
  logic        busy_res_o, byte_request_o, read_valid_o, done_res_o, success_o;
  logic [7:0]  read_data_o;

  i2c_register_master dut (.*);

  localparam result_t IdleOut = '{scl_level: 1'b1, scl_drive: 1'b1, sda_level: 1'b1,
                                   sda_drive: 1'b1, default: '0};
  localparam result_t StartOut = '{scl_level: 1'b1, scl_drive: 1'b1, sda_level: 1'b0,
                                    sda_drive: 1'b1, busy_res: 1'b1, default: '0};

  // bus model state
  logic [15:0] quarter_q = QuarterReset;
  logic [7:0]  stretch_q = StretchReset;
  phase_e      ph = PIdle;
  kind_e       kind = KDev;
  logic [15:0] tcnt = '0;
  logic [3:0]  bidx = '0;
  logic [7:0]  shreg = '0, left = '0, scnt = '0, dev_q = '0, sub_q = '0;
  logic        rd_mode = 1'b0, addr_ok = 1'b0;

  result_t     bus_results[$];
  int          errors = 0;
  int          send_idle = 0, recv_idle = 0;

  initial forever #10 clk_i = ~clk_i;

  function automatic logic [16:0] qlen();
    return (quarter_q == 0) ? 17'd1 : {1'b0, quarter_q};
  endfunction

  function automatic bit quarter_end();
    if ({1'b0, tcnt} + 17'd1 >= qlen()) begin
      tcnt = '0;
      return 1'b1;
    end
    tcnt = tcnt + 16'd1;
    return 1'b0;
  endfunction

  function automatic void goto(phase_e p);
    ph = p;
    tcnt = '0;
  endfunction

  function automatic void send_byte(logic [7:0] b);
    shreg = b;
    bidx = '0;
    goto(PWbLo1);
  endfunction

  function automatic void read_next();
    left = left - 8'd1;
    shreg = '0;
    bidx = '0;
    goto(PRbLo1);
  endfunction

  function automatic result_t bus_step(item_t it);
    result_t r;
    logic    wbit, ackl;
    r = IdleOut;
    wbit = shreg[3'd7 - bidx[2:0]];
    ackl = (left == 0);
    case (ph)
      PStart: r.sda_level = 1'b0;
      PWbLo1, PWbLo2: begin r.scl_level = 1'b0; r.sda_level = wbit; end
      PWbHi1, PWbHi2: r.sda_level = wbit;
      PAckLo1, PAckLo2: begin r.scl_level = 1'b0; r.sda_drive = 1'b0; end
      PAckStr: begin r.scl_drive = 1'b0; r.sda_drive = 1'b0; end
      PAckHi1: r.sda_drive = 1'b0;
      PRsLo1, PRsLo2, PWait: r.scl_level = 1'b0;
      PRbLo1, PRbLo2: begin r.scl_level = 1'b0; r.sda_drive = 1'b0; end
      PRbHi1, PRbHi2: r.sda_drive = 1'b0;
      PRaLo1, PRaLo2: begin r.scl_level = 1'b0; r.sda_level = ackl; end
      PRaHi1, PRaHi2: r.sda_level = ackl;
      PSpLo1, PSpLo2: begin r.scl_level = 1'b0; r.sda_level = 1'b0; end
      PSpHi: r.sda_level = 1'b0;
      default: ;
    endcase
    r.busy_res = (ph != PIdle);
    r.byte_request = (ph == PWait);

    case (ph)
      PIdle: if (it.opcode == OpWrite || it.opcode == OpRead) begin
        dev_q = it.device_addr;
        sub_q = it.sub_addr;
        left = it.byte_count;
        rd_mode = (it.opcode == OpRead);
        kind = KDev;
        addr_ok = 1'b1;
        shreg = it.device_addr;
        bidx = '0;
        goto(PStart);
      end
      PStart: if (quarter_end()) send_byte(shreg);
      PWbLo1, PWbLo2, PWbHi1, PAckLo1, PRsLo1, PRsLo2, PRbLo1, PRbLo2,
      PRaLo1, PRaLo2, PRaHi1, PSpLo1, PSpLo2, PSpHi, PSpEnd1:
        if (quarter_end()) ph = phase_e'(ph + 5'd1);
      PWbHi2: if (quarter_end()) begin
        bidx = bidx + 4'd1;
        ph = (bidx >= 8) ? PAckLo1 : PWbLo1;
      end
      PAckLo2: if (quarter_end()) begin
        scnt = '0;
        goto(PAckStr);
      end
      PAckStr: begin
        if (tcnt != 0) tcnt = tcnt - 16'd1;
        else if (it.scl_in || {1'b0, scnt} + 9'd1 >= {1'b0, stretch_q}) goto(PAckHi1);
        else begin
          scnt = scnt + 8'd1;
          tcnt = 16'(qlen() - 17'd1);
        end
      end
      PAckHi1: if (quarter_end()) begin
        if (it.sda_in && kind != KData) addr_ok = 1'b0;
        ph = PAckHi2;
      end
      PAckHi2: if (quarter_end()) begin
        if (!addr_ok) goto(PSpLo1);
        else case (kind)
          KDev: begin kind = KSub; send_byte(sub_q); end
          KSub: begin
            if (rd_mode) goto(PRsLo1);
            else begin
              kind = KData;
              goto(left != 0 ? PWait : PSpLo1);
            end
          end
          KDevr: begin
            kind = KData;
            if (left != 0) read_next(); else goto(PSpLo1);
          end
          default: goto(left != 0 ? PWait : PSpLo1);
        endcase
      end
      PRsHi: if (quarter_end()) begin
        kind = KDevr;
        shreg = dev_q | 8'h01;
        goto(PStart);
      end
      PWait: if (it.opcode == OpByte) begin
        left = left - 8'd1;
        send_byte(it.write_byte);
      end
      PRbHi1: if (quarter_end()) begin
        shreg = {shreg[6:0], it.sda_in};
        if (bidx == 4'd7) begin
          r.read_valid = 1'b1;
          r.read_data = shreg;
        end
        ph = PRbHi2;
      end
      PRbHi2: if (quarter_end()) begin
        bidx = bidx + 4'd1;
        ph = (bidx >= 8) ? PRaLo1 : PRbLo1;
      end
      PRaHi2: if (quarter_end()) begin
        if (left != 0) read_next(); else goto(PSpLo1);
      end
      PSpEnd2: if (quarter_end()) begin
        r.done_res = 1'b1;
        r.success = addr_ok;
        goto(PIdle);
      end
      default: goto(PIdle);
    endcase
    return r;
  endfunction

  task automatic send_beat(item_t it, bit typed, result_t want);
    result_t r;
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    opcode_i <= it.opcode;
    device_addr_i <= it.device_addr;
    sub_addr_i <= it.sub_addr;
    byte_count_i <= it.byte_count;
    write_byte_i <= it.write_byte;
    sda_in_i <= it.sda_in;
    scl_in_i <= it.scl_in;
    do @(posedge clk_i); while (full);
    r = bus_step(it);
    bus_results.push_back(typed ? want : r);
    @(negedge clk_i);
  endtask

  function automatic item_t pick_beat();
    item_t it;
    it.device_addr = 8'($urandom);
    if ($urandom_range(99) < 80) it.device_addr[0] = 1'b0;
    it.sub_addr = 8'($urandom);
    it.byte_count = ($urandom_range(99) < 2) ? 8'($urandom) : 8'($urandom_range(3));
    it.write_byte = 8'($urandom);
    it.scl_in = ($urandom_range(99) < 85);
    if (ph == PAckHi1) it.sda_in = ($urandom_range(99) < 10);
    else it.sda_in = 1'($urandom);
    if (ph == PIdle)
      it.opcode = ($urandom_range(99) < 85) ? ($urandom_range(1) ? OpWrite : OpRead)
                                            : ($urandom_range(1) ? OpTick : OpByte);
    else if (ph == PWait)
      it.opcode = ($urandom_range(99) < 80) ? OpByte : 2'($urandom);
    else
      it.opcode = ($urandom_range(99) < 90) ? OpTick : 2'($urandom);
    return it;
  endfunction

  task automatic run_random(int n);
    repeat (n) send_beat(pick_beat(), 1'b0, '0);
  endtask

  // finish the open transaction and let the result queue empty
  task automatic settle();
    item_t it;
    while (ph != PIdle) begin
      it = '0;
      it.opcode = (ph == PWait) ? OpByte : OpTick;
      it.write_byte = 8'($urandom);
      it.scl_in = 1'b1;
      send_beat(it, 1'b0, '0);
    end
    push <= 1'b0;
    while (bus_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgQuarter) quarter_q = data;
    else stretch_q = data[7:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(negedge clk_i) pop <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk_i) begin
    result_t w;
    if (rst_ni && pop && !empty) begin
      if (bus_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        w = bus_results.pop_front();
        check_field("scl_level", w.scl_level, scl_level_o);
        check_field("scl_drive", w.scl_drive, scl_drive_o);
        check_field("sda_level", w.sda_level, sda_level_o);
        check_field("sda_drive", w.sda_drive, sda_drive_o);
        check_field("busy_res", w.busy_res, busy_res_o);
        check_field("byte_request", w.byte_request, byte_request_o);
        check_field("read_data", w.read_data, read_data_o);
        check_field("read_valid", w.read_valid, read_valid_o);
        check_field("done_res", w.done_res, done_res_o);
        check_field("success", w.success, success_o);
      end
    end
  end

  initial begin
    #60_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    item_t   rows[20];
    bit      typed[20];
    result_t want[20];
    item_t   it;
    rows[0]  = '{OpTick,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1};
    rows[1]  = '{OpByte,  8'h00, 8'h00, 8'h00, 8'hff, 1'b0, 1'b1};
    rows[2]  = '{OpRead,  8'hfe, 8'hff, 8'h01, 8'h00, 1'b0, 1'b1};
    rows[3]  = '{OpTick,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1};
    rows[4]  = '{OpWrite, 8'h00, 8'h00, 8'hff, 8'h00, 1'b1, 1'b0};
    rows[5]  = '{OpByte,  8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1};
    for (int i = 6; i < 20; i++) rows[i] = '{OpTick, 8'hff, 8'hff, 8'hff, 8'hff, i[0], 1'b1};
    typed = '{default: 1'b0};
    want = '{default: '0};
    typed[0] = 1'b1; want[0] = IdleOut;
    typed[1] = 1'b1; want[1] = IdleOut;
    typed[2] = 1'b1; want[2] = IdleOut;
    typed[3] = 1'b1; want[3] = StartOut;

    send_idle = 26;
    recv_idle = 59;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int i = 0; i < 20; i++) send_beat(rows[i], typed[i], want[i]);
    settle();

    write_cfg(CfgQuarter, 16'd1);
    write_cfg(CfgStretch, 16'd0);
    run_random(250);
    settle();
    write_cfg(CfgQuarter, 16'd2);
    write_cfg(CfgStretch, 16'd255);
    run_random(250);
    settle();

    send_idle = 59;
    recv_idle = 26;
    write_cfg(CfgQuarter, 16'd0);
    write_cfg(CfgStretch, 16'd3);
    run_random(250);
    settle();

    send_idle = 0;
    recv_idle = 0;
    write_cfg(CfgQuarter, 16'd3);
    write_cfg(CfgStretch, 16'd1);
    run_random(280);
    settle();

    // widest quarter period: idle ticks only
    write_cfg(CfgQuarter, 16'hffff);
    write_cfg(CfgStretch, 16'd255);
    repeat (20) begin
      it = '0;
      it.opcode = OpTick;
      it.sda_in = 1'($urandom);
      it.scl_in = 1'($urandom);
      send_beat(it, 1'b0, '0);
    end
    settle();

    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

// ----- i2c_register_master.f -----
sv/i2c_reg_pkg.sv
sv/i2c_reg_engine.sv
sv/i2c_reg_queue.sv
sv/i2c_register_master.sv
sv/i2c_reg_checker.sv
tb/tb.sv
